// File: rtl/hps_pkg.sv
package hps_pkg;

  localparam int DUTY_BITS_DEFAULT    = 10;
  localparam int HEATER_COUNT_DEFAULT = 2;

  localparam int CUR_W  = 16;
  localparam int PCT_W  = 7;
  localparam int CAP_W  = 15;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;

  localparam logic [CAP_W-1:0] CAP_FULL  = 15'd25600;
  localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
  localparam logic [6:0]       ALPHA_NUM = 7'd77;
  localparam int               RAMP_MA   = 1000;
  // n / 10 == (n * 205) >> 11 for every n below 1029
  localparam logic [7:0]       DIV10_MUL = 8'd205;
  localparam int               DIV10_SH  = 11;

  localparam logic [CFG_AW-1:0] CFG_LIMIT_ENABLED = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_LIMIT_MA      = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_MAX_DUTY_A    = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_MAX_DUTY_B    = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_HEATER_ON_A   = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_HEATER_ON_B   = 3'd5;

  // x^5 * k, exact in 128 bits for x below 2^16 and k below 2^14
  function automatic logic [127:0] pow5k(input logic [127:0] x, input logic [127:0] k);
    logic [127:0] w;
    w = 128'd1;
    for (int i = 0; i < 5; i++) w = w * x;
    return w * k;
  endfunction

  // largest g with g^5 * 10^4 <= pwm^5 * p^2
  function automatic int unsigned gamma_duty(input int unsigned p, input int unsigned bits);
    int unsigned pwm;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    logic [127:0] rhs;
    pwm = (1 << bits) - 1;
    lo  = 0;
    hi  = pwm;
    if (p == 0) return 0;
    if (p >= 100) return pwm;
    rhs = pow5k(128'(pwm), 128'(p * p));
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (pow5k(128'(mid), 128'd10000) <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // largest r with r^2 * pwm^5 <= 10^4 * d^5
  function automatic int unsigned duty_to_percent(input int unsigned d, input int unsigned bits);
    int unsigned pwm;
    int unsigned r;
    logic [127:0] rhs;
    pwm = (1 << bits) - 1;
    r   = 0;
    if (d == 0) return 0;
    if (d >= pwm) return 100;
    rhs = pow5k(128'(d), 128'd10000);
    while (r < 100 && pow5k(128'(pwm), 128'((r + 1) * (r + 1))) <= rhs) r++;
    return r;
  endfunction

  // ceiling percent mapped linearly onto the duty range
  function automatic int unsigned ceil_duty(input int unsigned c, input int unsigned bits);
    int unsigned pwm;
    pwm = (1 << bits) - 1;
    if (c >= 100) return pwm;
    return (c * pwm) / 100;
  endfunction

endpackage

// File: rtl/hps_in_if.sv
interface hps_in_if;
  logic                      valid;
  logic                      ready;
  logic [hps_pkg::CUR_W-1:0] measured_current_ma;
  logic [hps_pkg::PCT_W-1:0] demand_a;
  logic [hps_pkg::PCT_W-1:0] demand_b;

  modport source (output valid, measured_current_ma, demand_a, demand_b, input ready);
  modport sink (input valid, measured_current_ma, demand_a, demand_b, output ready);
endinterface

// File: rtl/hps_out_if.sv
interface hps_out_if #(
  parameter int DUTY_BITS = hps_pkg::DUTY_BITS_DEFAULT
);
  logic                      valid;
  logic                      ready;
  logic [DUTY_BITS-1:0]      duty_a;
  logic [DUTY_BITS-1:0]      duty_b;
  logic [hps_pkg::PCT_W-1:0] reported_a;
  logic [hps_pkg::PCT_W-1:0] reported_b;
  logic [hps_pkg::PCT_W-1:0] cap_percent;
  logic                      limit_active;

  modport source (
    output valid, duty_a, duty_b, reported_a, reported_b, cap_percent, limit_active,
    input ready
  );
  modport sink (
    input valid, duty_a, duty_b, reported_a, reported_b, cap_percent, limit_active,
    output ready
  );
endinterface

// File: rtl/heater_pwm_stage_with_current_cap.sv
// timing: a tick is registered in the input register on acceptance, and its result is then
//   registered in the result register whenever the output is not stalled
// throughput: one transaction per cycle while the output is not stalled; the smoothed cap register is the only loop
// reset: synchronous, active high; clears both valid flags, loads the configuration
//   defaults and sets the smoothed cap to full scale
module heater_pwm_stage_with_current_cap #(
  parameter int DUTY_BITS    = hps_pkg::DUTY_BITS_DEFAULT,
  parameter int HEATER_COUNT = hps_pkg::HEATER_COUNT_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  hps_in_if.sink                     tick,
  hps_out_if.source                  result,
  input  logic                       cfg_we,
  input  logic [hps_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [hps_pkg::CFG_DW-1:0] cfg_wdata
);

  localparam int PW = hps_pkg::PCT_W;

  // configuration
  logic                      limit_enabled;
  logic [hps_pkg::CUR_W-1:0] limit_ma;
  logic [PW-1:0]             ceil_pct [0:1];
  logic                      heater_on [0:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_enabled <= 1'b0;
      limit_ma      <= '0;
      ceil_pct[0]   <= hps_pkg::PCT_FULL;
      ceil_pct[1]   <= hps_pkg::PCT_FULL;
      heater_on[0]  <= 1'b0;
      heater_on[1]  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        hps_pkg::CFG_LIMIT_ENABLED: limit_enabled <= cfg_wdata[0];
        hps_pkg::CFG_LIMIT_MA:      limit_ma      <= cfg_wdata;
        hps_pkg::CFG_MAX_DUTY_A:    ceil_pct[0]   <= cfg_wdata[PW-1:0];
        hps_pkg::CFG_MAX_DUTY_B:    ceil_pct[1]   <= cfg_wdata[PW-1:0];
        hps_pkg::CFG_HEATER_ON_A:   heater_on[0]  <= cfg_wdata[0];
        hps_pkg::CFG_HEATER_ON_B:   heater_on[1]  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // constant curves, built at elaboration
  logic [DUTY_BITS-1:0] gamma_tab [0:100];
  logic [DUTY_BITS-1:0] ceil_tab  [0:100];
  logic [PW-1:0]        rep_tab   [0:100];

  for (genvar i = 0; i <= 100; i++) begin : g_tab
    assign gamma_tab[i] = DUTY_BITS'(hps_pkg::gamma_duty(i, DUTY_BITS));
    assign ceil_tab[i]  = DUTY_BITS'(hps_pkg::ceil_duty(i, DUTY_BITS));
    // power actually delivered at the ceiling duty of percent i
    assign rep_tab[i]   = PW'(hps_pkg::duty_to_percent(hps_pkg::ceil_duty(i, DUTY_BITS),
                                                       DUTY_BITS));
  end

  // handshake
  logic in_valid;
  logic adv;

  assign adv        = in_valid && (!result.valid || result.ready);
  assign tick.ready = !in_valid || adv;

  // input register
  logic [hps_pkg::CUR_W-1:0] cur;
  logic [PW-1:0]             demand [0:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick.ready) begin
      in_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      cur       <= tick.measured_current_ma;
      demand[0] <= tick.demand_a;
      demand[1] <= tick.demand_b;
    end
  end

  // cap target and smoothing
  logic [hps_pkg::CAP_W-1:0] smoothed_cap;
  logic [hps_pkg::CAP_W-1:0] smoothed_cap_next;
  logic                      limiting;
  logic signed [17:0]        diff;
  logic [17:0]               div_prod;
  logic [PW-1:0]             target;
  logic [hps_pkg::CAP_W-1:0] tgt256;
  logic                      rising;
  logic [hps_pkg::CAP_W-1:0] mag;
  logic [21:0]               step_prod;
  logic [hps_pkg::CAP_W-1:0] step;
  logic [hps_pkg::CAP_W:0]   moved;
  logic [PW-1:0]             cap;

  always_comb begin
    limiting  = limit_enabled && (limit_ma != '0);
    diff      = $signed({2'b00, limit_ma}) - $signed({2'b00, cur});
    div_prod  = 18'(diff[9:0]) * 18'(hps_pkg::DIV10_MUL);
    if (diff >= 18'sd1000) begin
      target = hps_pkg::PCT_FULL;
    end else if (diff <= 18'sd0) begin
      target = '0;
    end else begin
      target = div_prod[hps_pkg::DIV10_SH +: PW];
    end
    tgt256    = {target, 8'b0};
    rising    = tgt256 >= smoothed_cap;
    mag       = rising ? (tgt256 - smoothed_cap) : (smoothed_cap - tgt256);
    // ceil(77 * |d| / 256)
    step_prod = 22'(mag) * 22'(hps_pkg::ALPHA_NUM) + 22'd255;
    step      = {1'b0, step_prod[21:8]};
    moved     = rising ? ({1'b0, smoothed_cap} + {1'b0, step})
                       : ({1'b0, smoothed_cap} - {1'b0, step});
    if (moved > {1'b0, hps_pkg::CAP_FULL}) begin
      smoothed_cap_next = hps_pkg::CAP_FULL;
    end else begin
      smoothed_cap_next = moved[hps_pkg::CAP_W-1:0];
    end
    cap = limiting ? smoothed_cap_next[hps_pkg::CAP_W-1:8] : hps_pkg::PCT_FULL;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed_cap <= hps_pkg::CAP_FULL;
    end else if (adv && limiting) begin
      smoothed_cap <= smoothed_cap_next;
    end
  end

  // heater lanes
  logic [DUTY_BITS-1:0] lane_duty [0:1];
  logic [PW-1:0]        lane_rep  [0:1];

  for (genvar h = 0; h < 2; h++) begin : g_lane
    if (h < HEATER_COUNT) begin : g_on
      logic [PW-1:0]        p;
      logic [PW-1:0]        c_max;
      logic [PW-1:0]        c;
      logic [DUTY_BITS-1:0] want;
      logic [DUTY_BITS-1:0] ceil_d;
      logic                 clamped;

      always_comb begin
        p       = (demand[h] > hps_pkg::PCT_FULL) ? hps_pkg::PCT_FULL : demand[h];
        c_max   = (ceil_pct[h] > hps_pkg::PCT_FULL) ? hps_pkg::PCT_FULL : ceil_pct[h];
        c       = (cap < c_max) ? cap : c_max;
        want    = gamma_tab[p];
        ceil_d  = ceil_tab[c];
        clamped = ceil_d < want;
        if (!heater_on[h]) begin
          lane_duty[h] = '0;
          lane_rep[h]  = '0;
        end else begin
          lane_duty[h] = clamped ? ceil_d : want;
          lane_rep[h]  = clamped ? rep_tab[c] : p;
        end
      end
    end else begin : g_off
      assign lane_duty[h] = '0;
      assign lane_rep[h]  = '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.duty_a       <= lane_duty[0];
      result.duty_b       <= lane_duty[1];
      result.reported_a   <= lane_rep[0];
      result.reported_b   <= lane_rep[1];
      result.cap_percent  <= cap;
      result.limit_active <= cap < hps_pkg::PCT_FULL;
    end
  end

  // checks
  a_cap_range: assert property (@(posedge clk) disable iff (rst)
    smoothed_cap <= hps_pkg::CAP_FULL)
    else $error("smoothed cap above full scale");

  a_cap_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(adv) |-> $stable(smoothed_cap))
    else $error("smoothed cap moved without a transaction");

  a_limit_flag: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.limit_active == (result.cap_percent < hps_pkg::PCT_FULL)))
    else $error("limit flag disagrees with cap");

  a_report_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.reported_a <= hps_pkg::PCT_FULL &&
                      result.reported_b <= hps_pkg::PCT_FULL))
    else $error("reported power above full scale");

endmodule

// File: sim/heater_pwm_stage_with_current_cap_test.sv
module heater_pwm_stage_with_current_cap_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DUTY_BITS = hps_pkg::DUTY_BITS_DEFAULT;
  localparam int HEATERS   = hps_pkg::HEATER_COUNT_DEFAULT;
  localparam int PW        = hps_pkg::PCT_W;
  localparam int PWM_TOP   = (1 << DUTY_BITS) - 1;
  localparam int RAMP_SPAN = 1000;
  localparam int SMOOTH_FULL = 25600;
  localparam int EMA_NUM     = 77;

  typedef struct packed {
    logic [DUTY_BITS-1:0]      duty_a;
    logic [DUTY_BITS-1:0]      duty_b;
    logic [hps_pkg::PCT_W-1:0] reported_a;
    logic [hps_pkg::PCT_W-1:0] reported_b;
    logic [hps_pkg::PCT_W-1:0] cap_percent;
    logic                      limit_active;
  } heat_result_t;

  class heat_scoreboard;
    heat_result_t expected_q[$];
    int unsigned  gamma_tab[0:100];
    int unsigned  pct_tab[0:PWM_TOP];
    bit           lim_en;
    int unsigned  lim_ma;
    int unsigned  maxd_a;
    int unsigned  maxd_b;
    bit           on_a;
    bit           on_b;
    int unsigned  smooth;
    int unsigned  errors;

    function new();
      logic [127:0] rhs;
      int unsigned  g;
      int unsigned  r;
      lim_en = 1'b0;
      lim_ma = 0;
      maxd_a = 100;
      maxd_b = 100;
      on_a   = 1'b0;
      on_b   = 1'b0;
      smooth = SMOOTH_FULL;
      errors = 0;
      // both curves are monotonic, so each search resumes where the last stopped
      g = 0;
      for (int p = 0; p <= 100; p++) begin
        rhs = pow5(PWM_TOP) * p * p;
        while (g < PWM_TOP && pow5(g + 1) * 10000 <= rhs) g++;
        gamma_tab[p] = g;
      end
      r = 0;
      for (int d = 0; d <= PWM_TOP; d++) begin
        rhs = pow5(d) * 10000;
        while (r < 100 && pow5(PWM_TOP) * (r + 1) * (r + 1) <= rhs) r++;
        pct_tab[d] = r;
      end
    endfunction

    function logic [127:0] pow5(logic [127:0] x);
      logic [127:0] w;
      w = x * x;
      return w * w * x;
    endfunction

    function void set_reg(logic [hps_pkg::CFG_AW-1:0] idx, logic [hps_pkg::CFG_DW-1:0] v);
      case (idx)
        hps_pkg::CFG_LIMIT_ENABLED: lim_en = v[0];
        hps_pkg::CFG_LIMIT_MA:      lim_ma = v;
        hps_pkg::CFG_MAX_DUTY_A:    maxd_a = v[6:0];
        hps_pkg::CFG_MAX_DUTY_B:    maxd_b = v[6:0];
        hps_pkg::CFG_HEATER_ON_A:   on_a = v[0];
        hps_pkg::CFG_HEATER_ON_B:   on_b = v[0];
        default: ;
      endcase
    endfunction

    function void heater_out(bit on, int unsigned dem, int unsigned maxd, int unsigned cap,
                             output int unsigned duty, output int unsigned rep);
      int unsigned p;
      int unsigned c;
      int unsigned ceil_d;
      int unsigned want;
      if (!on) begin
        duty = 0;
        rep  = 0;
        return;
      end
      p = (dem > 100) ? 100 : dem;
      c = (maxd > 100) ? 100 : maxd;
      if (cap < c) c = cap;
      ceil_d = (c >= 100) ? PWM_TOP : (c * PWM_TOP) / 100;
      want = gamma_tab[p];
      duty = (want < ceil_d) ? want : ceil_d;
      rep  = (duty < want) ? pct_tab[duty] : p;
    endfunction

    function void note_tick(logic [15:0] cur, logic [6:0] da, logic [6:0] db);
      heat_result_t e;
      int unsigned  cap;
      int unsigned  target;
      int unsigned  tgt;
      int unsigned  duty;
      int unsigned  rep;
      cap = 100;
      if (lim_en && lim_ma != 0) begin
        if (int'(cur) <= int'(lim_ma) - RAMP_SPAN) target = 100;
        else if (cur >= lim_ma) target = 0;
        else target = (lim_ma - cur) / 10;
        tgt = target * 256;
        // rounded-up step never overshoots yet always moves, so it settles exactly on target
        if (tgt >= smooth) smooth += (EMA_NUM * (tgt - smooth) + 255) >> 8;
        else smooth -= (EMA_NUM * (smooth - tgt) + 255) >> 8;
        if (smooth > SMOOTH_FULL) smooth = SMOOTH_FULL;
        cap = smooth >> 8;
      end
      heater_out(on_a, da, maxd_a, cap, duty, rep);
      e.duty_a     = DUTY_BITS'(duty);
      e.reported_a = PW'(rep);
      if (HEATERS >= 2) begin
        heater_out(on_b, db, maxd_b, cap, duty, rep);
      end else begin
        duty = 0;
        rep  = 0;
      end
      e.duty_b       = DUTY_BITS'(duty);
      e.reported_b   = PW'(rep);
      e.cap_percent  = PW'(cap);
      e.limit_active = (cap < 100);
      expected_q.push_back(e);
    endfunction

    function void cmp_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(heat_result_t act);
      heat_result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual %h", $time, act);
        return;
      end
      e = expected_q.pop_front();
      cmp_field("duty_a", e.duty_a, act.duty_a);
      cmp_field("duty_b", e.duty_b, act.duty_b);
      cmp_field("reported_a", e.reported_a, act.reported_a);
      cmp_field("reported_b", e.reported_b, act.reported_b);
      cmp_field("cap_percent", e.cap_percent, act.cap_percent);
      cmp_field("limit_active", e.limit_active, act.limit_active);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                        cfg_we;
  logic [hps_pkg::CFG_AW-1:0]  cfg_addr;
  logic [hps_pkg::CFG_DW-1:0]  cfg_wdata;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  heat_result_t seen_result;
  heat_scoreboard sb = new();

  hps_in_if tick();
  hps_out_if #(.DUTY_BITS(DUTY_BITS)) result();

  heater_pwm_stage_with_current_cap #(
    .DUTY_BITS(DUTY_BITS),
    .HEATER_COUNT(HEATERS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .tick(tick),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

  always @(negedge clk) begin
    result.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result.valid && result.ready) begin
        seen_result.duty_a       = result.duty_a;
        seen_result.duty_b       = result.duty_b;
        seen_result.reported_a   = result.reported_a;
        seen_result.reported_b   = result.reported_b;
        seen_result.cap_percent  = result.cap_percent;
        seen_result.limit_active = result.limit_active;
        sb.check_result(seen_result);
      end
      if (tick.valid && tick.ready)
        sb.note_tick(tick.measured_current_ma, tick.demand_a, tick.demand_b);
    end
  end

  task automatic send_tick(logic [15:0] cur, logic [6:0] da, logic [6:0] db);
    while ($urandom_range(99) < send_idle_pct) begin
      tick.valid <= 1'b0;
      @(negedge clk);
    end
    tick.valid               <= 1'b1;
    tick.measured_current_ma <= cur;
    tick.demand_a            <= da;
    tick.demand_b            <= db;
    @(posedge clk);
    while (!tick.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    tick.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic configure(bit le, int unsigned lim, int unsigned ma, int unsigned mb,
                           bit oa, bit ob);
    logic [hps_pkg::CFG_AW-1:0] addrs[6];
    logic [hps_pkg::CFG_DW-1:0] vals[6];
    addrs = '{hps_pkg::CFG_LIMIT_ENABLED, hps_pkg::CFG_LIMIT_MA, hps_pkg::CFG_MAX_DUTY_A,
              hps_pkg::CFG_MAX_DUTY_B, hps_pkg::CFG_HEATER_ON_A, hps_pkg::CFG_HEATER_ON_B};
    vals  = '{16'(le), 16'(lim), 16'(ma), 16'(mb), 16'(oa), 16'(ob)};
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= addrs[i];
      cfg_wdata <= vals[i];
      sb.set_reg(addrs[i], vals[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_current(int unsigned lim);
    int v;
    case ($urandom_range(3))
      0: v = $urandom_range(65535);
      1: v = int'(lim) - int'($urandom_range(RAMP_SPAN));
      default: v = int'(lim) - 1100 + int'($urandom_range(1200));
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  function automatic logic [6:0] pick_pct();
    case ($urandom_range(9))
      0: return 7'd0;
      1: return 7'd100;
      2: return 7'($urandom_range(127));
      default: return 7'($urandom_range(100));
    endcase
  endfunction

  function automatic int unsigned pick_limit();
    case ($urandom_range(6))
      0: return 0;
      1: return $urandom_range(1, 999);
      2: return 65535;
      default: return $urandom_range(1000, 30000);
    endcase
  endfunction

  initial begin
    int unsigned lim;
    tick.valid               = 1'b0;
    tick.measured_current_ma = '0;
    tick.demand_a            = '0;
    tick.demand_b            = '0;
    cfg_we                   = 1'b0;
    cfg_addr                 = '0;
    cfg_wdata                = '0;
    send_idle_pct            = 23;
    recv_idle_pct            = 88;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // limiting off, gamma curve extremes and saturated demands
    configure(1'b0, 0, 100, 100, 1'b1, 1'b1);
    send_tick(16'd0, 7'd0, 7'd100);
    send_tick(16'd0, 7'd1, 7'd99);
    send_tick(16'hffff, 7'd50, 7'd101);
    send_tick(16'd0, 7'd127, 7'd2);
    send_tick(16'd1234, 7'd100, 7'd127);
    drain();

    // ramp edges, over-range max duty on a, zero ceiling on b
    configure(1'b1, 5000, 127, 0, 1'b1, 1'b1);
    send_tick(16'd0, 7'd100, 7'd50);
    send_tick(16'd4000, 7'd80, 7'd1);
    send_tick(16'd4001, 7'd100, 7'd100);
    send_tick(16'd4500, 7'd100, 7'd0);
    send_tick(16'd4999, 7'd60, 7'd127);
    send_tick(16'd5000, 7'd100, 7'd100);
    send_tick(16'hffff, 7'd30, 7'd10);
    send_tick(16'd3000, 7'd100, 7'd100);
    drain();

    // limit below the ramp span, heater b off
    configure(1'b1, 500, 50, 100, 1'b1, 1'b0);
    send_tick(16'd0, 7'd100, 7'd100);
    send_tick(16'd499, 7'd70, 7'd100);
    send_tick(16'd500, 7'd100, 7'd40);
    drain();

    // zero limit disables limiting even when enabled
    configure(1'b1, 0, 100, 100, 1'b0, 1'b1);
    send_tick(16'd0, 7'd100, 7'd100);
    send_tick(16'hffff, 7'd55, 7'd33);
    drain();

    configure(1'b0, 65535, 100, 100, 1'b1, 1'b1);
    send_tick(16'hffff, 7'd100, 7'd100);
    send_tick(16'd0, 7'd75, 7'd25);
    drain();

    for (int seg = 0; seg < 10; seg++) begin
      if (seg < 3) begin
        send_idle_pct = 23;
        recv_idle_pct = 88;
      end else if (seg < 6) begin
        send_idle_pct = 88;
        recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      lim = pick_limit();
      drain();
      configure(($urandom_range(4) != 0), lim, pick_pct(), pick_pct(),
                ($urandom_range(5) != 0), ($urandom_range(5) != 0));
      for (int i = 0; i < 80; i++) begin
        // halfway through, the sender holds off until every outstanding result is back
        if (i == 40) drain();
        send_tick(pick_current(lim), pick_pct(), pick_pct());
      end
    end

    tick.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
